FILE: rtl/ppc_pkg.sv
// Shared types, widths and the Mobius table for the perfect power counter.
`timescale 1ns / 1ps

package ppc_pkg;

  localparam int DEF_INPUT_BITS = 63;
  localparam int LIMIT_W        = 63;
  localparam int COUNT_W        = 32;
  localparam int IN_TDATA_W     = 64;
  localparam int OUT_TDATA_W    = 32;
  // signed running total; partial sums stay well inside this range
  localparam int TOTAL_W        = 35;

  localparam logic signed [1:0] MU_Z = 2'sb00;
  localparam logic signed [1:0] MU_P = 2'sb01;
  localparam logic signed [1:0] MU_N = 2'sb11;

  localparam logic signed [1:0] MOBIUS_TABLE [65] = '{
    MU_Z, MU_P, MU_N, MU_N, MU_Z, MU_N, MU_P, MU_N,
    MU_Z, MU_Z, MU_P, MU_N, MU_Z, MU_N, MU_P, MU_P,
    MU_Z, MU_N, MU_Z, MU_N, MU_Z, MU_P, MU_P, MU_N,
    MU_Z, MU_Z, MU_P, MU_Z, MU_Z, MU_N, MU_N, MU_N,
    MU_Z, MU_P, MU_P, MU_P, MU_Z, MU_N, MU_P, MU_P,
    MU_Z, MU_N, MU_N, MU_N, MU_Z, MU_Z, MU_P, MU_N,
    MU_Z, MU_Z, MU_Z, MU_P, MU_Z, MU_N, MU_Z, MU_P,
    MU_Z, MU_P, MU_P, MU_N, MU_Z, MU_N, MU_P, MU_Z,
    MU_Z
  };

  typedef struct packed {
    logic load;
    logic blen_step;
    logic k_init;
    logic k_inc;
    logic ceil_init;
    logic ceil_step;
    logic bit_init;
    logic try_init;
    logic mul_lo;
    logic mul_hi;
    logic cmp;
    logic bit_dec;
    logic acc;
    logic out_load;
  } ppc_cmd_t;

  typedef struct packed {
    logic copy_zero;
    logic k_over;
    logic mu_zero;
    logic rem_zero;
    logic fits;
    logic mult_last;
    logic bit_zero;
    logic out_free;
  } ppc_status_t;

endpackage

FILE: rtl/ppc_datapath.sv
// Datapath: bit length, root search with split multiply, running total, output register.
`timescale 1ns / 1ps

module ppc_datapath #(
  parameter int INPUT_BITS = ppc_pkg::DEF_INPUT_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ppc_pkg::ppc_cmd_t                  cmd,
  output ppc_pkg::ppc_status_t               status,
  input  logic [ppc_pkg::IN_TDATA_W-1:0]     in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ppc_pkg::COUNT_W-1:0]        out_data
);

  localparam int W   = INPUT_BITS;
  localparam int RW  = (W + 1) / 2;
  localparam int BLW = $clog2(W + 1);
  localparam int KW  = $clog2(W + 2);
  localparam int BIW = $clog2(RW);
  localparam int SW  = $clog2(RW + 1);
  localparam int FW  = W + RW;
  localparam int TW  = ppc_pkg::TOTAL_W;

  logic [W-1:0]        n;
  logic [W-1:0]        copy;
  logic [BLW-1:0]      bits;
  logic [KW-1:0]       k;
  logic [BLW-1:0]      rem;
  logic [SW-1:0]       s;
  logic [BIW-1:0]      b;
  logic [RW-1:0]       r;
  logic [RW-1:0]       cand;
  logic [W-1:0]        t;
  logic [KW-1:0]       j;
  logic [2*RW-1:0]     p_lo;
  logic [W-1:0]        p_hi;
  logic signed [TW-1:0] total;

  logic [FW-1:0]        full;
  logic signed [1:0]    mu;
  logic                 fits;
  logic signed [TW-1:0] term;

  assign mu   = ppc_pkg::MOBIUS_TABLE[7'(k)];
  assign full = {p_hi, {RW{1'b0}}} + FW'(p_lo);
  assign fits = full <= FW'(n);
  assign term = TW'(r) - TW'(1);

  assign status.copy_zero = copy == '0;
  assign status.k_over    = k > KW'(bits);
  assign status.mu_zero   = mu == ppc_pkg::MU_Z;
  assign status.rem_zero  = rem == '0;
  assign status.fits      = fits;
  assign status.mult_last = j == KW'(1);
  assign status.bit_zero  = b == '0;
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n     <= in_data[W-1:0];
      copy  <= in_data[W-1:0];
      bits  <= '0;
      total <= (in_data[W-1:0] != '0) ? TW'(1) : '0;
    end
    if (cmd.blen_step) begin
      copy <= copy >> 1;
      bits <= bits + BLW'(1);
    end
    if (cmd.k_init) k <= KW'(2);
    if (cmd.k_inc)  k <= k + KW'(1);
    if (cmd.ceil_init) begin
      rem <= bits;
      s   <= '0;
    end
    if (cmd.ceil_step) begin
      // saturating subtract; s ends as ceil(bits / k)
      rem <= (KW'(rem) > k) ? rem - k[BLW-1:0] : '0;
      s   <= s + SW'(1);
    end
    if (cmd.bit_init) begin
      b <= BIW'(s - SW'(1));
      r <= '0;
    end
    if (cmd.try_init) begin
      cand <= r | (RW'(1) << b);
      t    <= W'(1);
      j    <= k;
    end
    if (cmd.mul_lo) p_lo <= t[RW-1:0] * cand;
    if (cmd.mul_hi) p_hi <= W'(t[W-1:RW] * cand);
    if (cmd.cmp && fits) begin
      t <= full[W-1:0];
      j <= j - KW'(1);
      if (j == KW'(1)) r <= cand;
    end
    if (cmd.bit_dec) b <= b - BIW'(1);
    if (cmd.acc && r >= RW'(2)) begin
      total <= (mu == ppc_pkg::MU_P) ? total - term : total + term;
    end
    if (cmd.out_load) out_data <= total[ppc_pkg::COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/ppc_ctrl.sv
// Controller: sequences bit length, exponent scan, root bit trials and result hand-off.
`timescale 1ns / 1ps

module ppc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ppc_pkg::ppc_status_t status,
  output ppc_pkg::ppc_cmd_t    cmd
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_BLEN = 11'b000_0000_0010,
    S_KSEL = 11'b000_0000_0100,
    S_CEIL = 11'b000_0000_1000,
    S_TRY  = 11'b000_0001_0000,
    S_MLO  = 11'b000_0010_0000,
    S_MHI  = 11'b000_0100_0000,
    S_CMP  = 11'b000_1000_0000,
    S_NBIT = 11'b001_0000_0000,
    S_ACC  = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_BLEN;
        end
      end
      S_BLEN: begin
        if (status.copy_zero) begin
          cmd.k_init = 1'b1;
          state_next = S_KSEL;
        end else begin
          cmd.blen_step = 1'b1;
        end
      end
      S_KSEL: begin
        if (status.k_over) begin
          state_next = S_DONE;
        end else if (status.mu_zero) begin
          cmd.k_inc = 1'b1;
        end else begin
          cmd.ceil_init = 1'b1;
          state_next    = S_CEIL;
        end
      end
      S_CEIL: begin
        if (status.rem_zero) begin
          cmd.bit_init = 1'b1;
          state_next   = S_TRY;
        end else begin
          cmd.ceil_step = 1'b1;
        end
      end
      S_TRY: begin
        cmd.try_init = 1'b1;
        state_next   = S_MLO;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        // drop the trial on overflow, keep it after the last factor
        if (!status.fits || status.mult_last) begin
          state_next = S_NBIT;
        end else begin
          state_next = S_MLO;
        end
      end
      S_NBIT: begin
        if (status.bit_zero) begin
          state_next = S_ACC;
        end else begin
          cmd.bit_dec = 1'b1;
          state_next  = S_TRY;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        cmd.k_inc  = 1'b1;
        state_next = S_KSEL;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/perfect_power_counter_unit.sv
// Top level of the perfect power counter: stream ports, controller and datapath.
//
//  channel   dir  beat content
//  s_axis    in   tdata[62:0] limit_value, tdata[63] zero
//  m_axis    out  tdata[31:0] power_count
//
// One limit at a time. For each exponent k with nonzero Mobius value the root
// is built one bit per trial in ceil(bitlen/k) trials; each trial multiplies
// up to k factors through the split 32x32 multiply in the datapath.
// Synchronous reset clears the controller and output valid. A result waits
// in the output register; the next limit is taken while it waits, and the
// block holds its finished count until the register frees.
`timescale 1ns / 1ps

module perfect_power_counter_unit #(
  parameter int INPUT_BITS = ppc_pkg::DEF_INPUT_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ppc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [62:0] limit_value
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ppc_pkg::OUT_TDATA_W-1:0] m_axis_tdata    // [31:0] power_count
);

  ppc_pkg::ppc_cmd_t    cmd;
  ppc_pkg::ppc_status_t status;

  ppc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ppc_datapath #(
    .INPUT_BITS (INPUT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
